@@ src/spq_pkg.sv @@
// Shared types, codes and sizes for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int HELD_W   = 5;

	localparam logic [1:0] CMD_ENQ  = 2'd0;
	localparam logic [1:0] CMD_DEQ  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic       insert;
		logic       remove;
		logic       capture;
		logic       show_head;
		logic [1:0] status;
	} spq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
	} spq_stat_t;

	// count reported modulo 32
	function automatic logic [HELD_W-1:0] to_held(input logic [CNT_W-1:0] count);
		logic [CNT_W+HELD_W-1:0] wide;
		wide = {{HELD_W{1'b0}}, count};
		return wide[HELD_W-1:0];
	endfunction

endpackage

@@ src/spq_ctrl.sv @@
// Controller: handshake, command decode and result hold state.
`timescale 1ns / 1ps

module spq_ctrl
	import spq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	output logic       out_valid,
	input  logic       out_ready,
	input  spq_stat_t  stat,
	output spq_cmd_t   ctl
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_HOLD = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	assign in_ready  = (state_q == ST_IDLE) || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == ST_HOLD);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (out_ready && !accept) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ctl = '0;
		ctl.capture = accept;
		ctl.status  = ST_OK;
		unique case (cmd)
			CMD_ENQ: begin
				if (stat.full) ctl.status = ST_FULL;
				else           ctl.insert = accept;
			end
			CMD_DEQ: begin
				if (stat.empty) begin
					ctl.status = ST_EMPTY;
				end else begin
					ctl.remove    = accept;
					ctl.show_head = 1'b1;
				end
			end
			CMD_PEEK: begin
				if (stat.empty) ctl.status = ST_EMPTY;
				else            ctl.show_head = 1'b1;
			end
			default: ctl.status = ST_OK;
		endcase
	end

endmodule

@@ src/spq_datapath.sv @@
// Datapath: sorted shift array of slots, fill count and result register.
`timescale 1ns / 1ps

module spq_datapath
	import spq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  spq_cmd_t                 ctl,
	output spq_stat_t                stat,
	input  logic signed [DATA_W-1:0] item_value,
	input  logic signed [DATA_W-1:0] item_priority,
	output logic        [1:0]        status,
	output logic signed [DATA_W-1:0] head_value,
	output logic signed [DATA_W-1:0] head_priority,
	output logic        [HELD_W-1:0] entries_held
);

	logic signed [DATA_W-1:0] val_q [CAPACITY];
	logic signed [DATA_W-1:0] pri_q [CAPACITY];
	logic        [CNT_W-1:0]  fill_q;
	logic        [CNT_W-1:0]  fill_d;
	logic        [CAPACITY-1:0] gt;

	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == CNT_W'(CAPACITY));

	always_comb begin
		if (ctl.insert)      fill_d = fill_q + 1'b1;
		else if (ctl.remove) fill_d = fill_q - 1'b1;
		else                 fill_d = fill_q;
	end

	// gt is a thermometer: slots behind the insert point rank strictly after the new item
	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_slot
			logic ins_here;
			logic shift_in;
			assign gt[i] = (CNT_W'(i) < fill_q) && (pri_q[i] > item_priority);
			if (i == 0) begin : g_front
				assign shift_in = 1'b0;
				assign ins_here = gt[i] || (fill_q == '0);
			end else begin : g_rest
				assign shift_in = gt[i-1];
				assign ins_here = !gt[i-1] && (gt[i] || (fill_q == CNT_W'(i)));
			end

			always_ff @(posedge clk) begin
				if (ctl.insert) begin
					if (shift_in) begin
						val_q[i] <= val_q[i-((i > 0) ? 1 : 0)];
						pri_q[i] <= pri_q[i-((i > 0) ? 1 : 0)];
					end else if (ins_here) begin
						val_q[i] <= item_value;
						pri_q[i] <= item_priority;
					end
				end else if (ctl.remove && (i < CAPACITY - 1)) begin
					val_q[i] <= val_q[i+((i < CAPACITY - 1) ? 1 : 0)];
					pri_q[i] <= pri_q[i+((i < CAPACITY - 1) ? 1 : 0)];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			status        <= ctl.status;
			head_value    <= ctl.show_head ? val_q[0] : '0;
			head_priority <= ctl.show_head ? pri_q[0] : '0;
			entries_held  <= to_held(fill_d);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.insert && ctl.remove))
		else $error("insert and remove in one cycle");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.insert |=> fill_q == CNT_W'($past(fill_q) + 1'b1))
		else $error("insert did not grow the count");

	a_full_no_insert: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !ctl.insert)
		else $error("insert into a full queue");

endmodule

@@ src/sorted_priority_queue_core.sv @@
// Top level of the sorted priority queue: stream ports, controller and datapath.
`timescale 1ns / 1ps
//
// Bounded, stable min-first priority queue held as a sorted shift array.
// Input channel s_axis_*: one transaction is one command (enqueue, dequeue
// front, peek front) with its data word and signed priority. Output channel
// m_axis_*: one transaction per command with status (ok, empty, full), the
// front entry's data and priority on a good dequeue or peek (zero otherwise)
// and the entry count after the command.
// Latency: the result is registered and appears the cycle after the command
// transaction. Throughput: one command per cycle while the receiver takes
// each result; every slot compares its priority with the new one in parallel
// and the whole array shifts in that same cycle, which sets the rate.
// Equal priorities queue behind one another, so arrival order is kept.
// Enqueue on a full queue is reported and dropped.
// Reset (arst_n low) empties the queue at once; slot contents are not
// cleared, since only slots below the count are ever read.
// Receiver stall: the result holds on m_axis_tdata; a new command is only
// taken in a cycle in which the waiting result leaves, so one result at most
// is ever pending.
//
module sorted_priority_queue_core
	import spq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] cmd, [33:2] item_value, [65:34] item_priority, [71:66] zero
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] status, [33:2] head_value, [65:34] head_priority,
	// [70:66] entries_held, [71] zero
	output logic [71:0] m_axis_tdata
);

	spq_cmd_t  ctl;
	spq_stat_t stat;

	logic        [1:0]        res_status;
	logic signed [DATA_W-1:0] res_value;
	logic signed [DATA_W-1:0] res_priority;
	logic        [HELD_W-1:0] res_held;

	// decode, handshake and result hold
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cmd       (s_axis_tdata[1:0]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// slots, count and result register
	spq_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.item_value    ($signed(s_axis_tdata[33:2])),
		.item_priority ($signed(s_axis_tdata[65:34])),
		.status        (res_status),
		.head_value    (res_value),
		.head_priority (res_priority),
		.entries_held  (res_held)
	);

	assign m_axis_tdata = {1'b0, res_held, res_priority, res_value, res_status};

endmodule
